FILE: rtl/tcde_pkg.sv
// Shared types, constants and helper functions of the terminal cell delta encoder.
package tcde_pkg;

   // Request codes on req_type
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_CELL  = 2'd1;
   localparam logic [1:0] REQ_END   = 2'd2;

   // Default geometry of the shown-cell store
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 64;

   // Register reset value and computed-width size
   localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
   localparam int         WIDTH_W          = 9;

   // Stored cell: back RGB, fore RGB, glyph
   localparam int          CELL_W     = 56;
   localparam logic [55:0] CELL_RESET = {24'h010101, 24'h010101, 8'h21};

   localparam int QUEUE_DEPTH = 4;

   // Byte slot template of the back end
   localparam int SLOT_W     = 7;
   localparam int SLOT_CUR   = 0;
   localparam int SLOT_BACK  = 10;
   localparam int SLOT_FORE  = 29;
   localparam int SLOT_GLYPH = 48;
   localparam int SLOT_START = 51;
   localparam int SLOT_END   = 59;
   localparam int NUM_SLOTS  = 71;

   // Character codes
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_FOUR  = 8'h34;
   localparam logic [7:0] CH_SIX   = 8'h36;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_BIG_H = 8'h48;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] GLYPH_HALF = 8'h01;
   localparam logic [7:0] UTF_B0   = 8'hE2;
   localparam logic [7:0] UTF_B1   = 8'h96;
   localparam logic [7:0] UTF_B2   = 8'h80;

   typedef enum logic [1:0] {JOB_START, JOB_END, JOB_CELL} job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [5:0]   row;
      logic [6:0]   column;
      logic [23:0]  back;
      logic [23:0]  fore;
      logic [7:0]   glyph;
      logic [11:0]  row_bcd;
      logic [11:0]  col_bcd;
      logic [11:0]  br_bcd;
      logic [11:0]  bg_bcd;
      logic [11:0]  bb_bcd;
      logic [11:0]  fr_bcd;
      logic [11:0]  fg_bcd;
      logic [11:0]  fb_bcd;
   } job_type;

   // Binary to three BCD digits, shift-and-add-3
   function automatic logic [11:0] to_bcd(input logic [7:0] v);
      logic [11:0] bcd;
      bcd = '0;
      for (int i = 7; i >= 0; i--) begin
         if (bcd[3:0] >= 4'd5) bcd[3:0] = bcd[3:0] + 4'd3;
         if (bcd[7:4] >= 4'd5) bcd[7:4] = bcd[7:4] + 4'd3;
         if (bcd[11:8] >= 4'd5) bcd[11:8] = bcd[11:8] + 4'd3;
         bcd = {bcd[10:0], v[i]};
      end
      return bcd;
   endfunction

endpackage

FILE: rtl/tcde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

FILE: rtl/tcde_front.sv
// Front end: accepts requests, compares cells with the store, queues output jobs.
module tcde_front #(
   parameter int MAX_COLUMNS = tcde_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tcde_pkg::DEF_MAX_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        line_width,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [5:0]        req_row,
   input  logic [6:0]        req_column,
   input  logic [23:0]       req_back,
   input  logic [23:0]       req_fore,
   input  logic [7:0]        req_glyph,
   output logic              job_valid,
   input  logic              job_ready,
   output tcde_pkg::job_type job_data,
   output logic              clearing
);
   import tcde_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [WIDTH_W-1:0] COL_LIM  = WIDTH_W'(MAX_COLUMNS);
   localparam logic [WIDTH_W-1:0] ROW_LIM  = WIDTH_W'(MAX_ROWS);
   localparam logic [AW-1:0]      LAST_IDX = AW'(DEPTH - 1);

   logic [WIDTH_W-1:0] width_used;
   logic               in_range;
   logic [15:0]        addr_full;
   logic               accept;

   logic               clear_ff, clear_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_type_ff;
   logic               s1_range_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [5:0]         s1_row_ff;
   logic [6:0]         s1_col_ff;
   logic [CELL_W-1:0]  s1_cell_ff;
   logic               fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]      fwd_addr_ff;
   logic [CELL_W-1:0]  fwd_data_ff;

   logic [CELL_W-1:0]  ram_rd;
   logic [CELL_W-1:0]  stored;
   logic               changed, has_out, s1_adv;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [CELL_W-1:0]  wr_data;

   // Store index from the request position
   assign width_used = ({1'b0, line_width} > COL_LIM) ? COL_LIM : {1'b0, line_width};
   assign in_range   = (req_type == REQ_CELL) && ({2'b0, req_column} < width_used)
                       && ({3'b0, req_row} < ROW_LIM);
   assign addr_full  = 16'({10'b0, req_row} * {7'b0, width_used}) + {9'b0, req_column};

   assign req_ready  = !clear_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_valid && req_ready;
   assign clearing   = clear_ff;

   // Compare stage, with the last write forwarded over the read data
   assign stored  = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : ram_rd;
   assign changed = s1_range_ff && (stored != s1_cell_ff);
   assign has_out = (s1_type_ff == REQ_START) || (s1_type_ff == REQ_END) || changed;
   assign s1_adv  = s1_valid_ff && (!has_out || job_ready);
   assign job_valid = s1_valid_ff && has_out;

   always_comb begin
      job_data.kind    = (s1_type_ff == REQ_START) ? JOB_START :
                         (s1_type_ff == REQ_END)   ? JOB_END : JOB_CELL;
      job_data.row     = s1_row_ff;
      job_data.column  = s1_col_ff;
      job_data.back    = s1_cell_ff[55:32];
      job_data.fore    = s1_cell_ff[31:8];
      job_data.glyph   = s1_cell_ff[7:0];
      job_data.row_bcd = to_bcd({2'b0, s1_row_ff} + 8'd1);
      job_data.col_bcd = to_bcd({1'b0, s1_col_ff} + 8'd1);
      job_data.br_bcd  = to_bcd(s1_cell_ff[55:48]);
      job_data.bg_bcd  = to_bcd(s1_cell_ff[47:40]);
      job_data.bb_bcd  = to_bcd(s1_cell_ff[39:32]);
      job_data.fr_bcd  = to_bcd(s1_cell_ff[31:24]);
      job_data.fg_bcd  = to_bcd(s1_cell_ff[23:16]);
      job_data.fb_bcd  = to_bcd(s1_cell_ff[15:8]);
   end

   // Store writes: clearing sweep, then changed cells
   always_comb begin
      wr_en   = clear_ff || (s1_adv && changed);
      wr_addr = clear_ff ? clr_cnt_ff : s1_addr_ff;
      wr_data = clear_ff ? CELL_RESET : s1_cell_ff;
   end

   always_comb begin
      clear_in     = clear_ff && (clr_cnt_ff != LAST_IDX);
      clr_cnt_in   = clear_ff ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      fwd_valid_in = fwd_valid_ff || wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      if (accept) begin
         s1_type_ff  <= req_type;
         s1_range_ff <= in_range;
         s1_addr_ff  <= addr_full[AW-1:0];
         s1_row_ff   <= req_row;
         s1_col_ff   <= req_column;
         s1_cell_ff  <= {req_back, req_fore, req_glyph};
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   tcde_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (addr_full[AW-1:0]),
      .rd_data (ram_rd)
   );

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_ready) else $error("request taken during store clear");
   a_no_cell_write_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s1_valid_ff) else $error("compare stage busy during clear");
   a_out_of_range_quiet: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_range_ff) |-> !changed) else $error("out of range cell changed");
endmodule

FILE: rtl/tcde_queue.sv
// Short job queue between the front and back ends.
module tcde_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tcde_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tcde_pkg::job_type pop_data
);
   import tcde_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      head_in  = do_pop ? PW'(head_ff + PW'(1)) : head_ff;
      tail_in  = do_push ? PW'(tail_ff + PW'(1)) : tail_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end
endmodule

FILE: rtl/tcde_back.sv
// Back end: tracks cursor and color caches and streams the escape text bytes.
module tcde_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  tcde_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_byte
);
   import tcde_pkg::*;

   job_type               job_ff;
   logic                  active_ff, active_in;
   logic [NUM_SLOTS-1:0]  mask_ff, mask_in, new_mask, rest;
   logic [23:0]           cback_ff, cfore_ff;
   logic                  bknown_ff, fknown_ff, curknown_ff;
   logic [5:0]            currow_ff;
   logic [7:0]            curcol_ff;
   logic                  need_cur, need_back, need_fore;
   logic                  load;
   logic [SLOT_W-1:0]     pc;

   // Leading-zero suppression for three digits; bit 0 enables the hundreds slot
   function automatic logic [2:0] dig_en(input logic [11:0] bcd);
      return {1'b1, (bcd[11:8] != 4'd0) || (bcd[7:4] != 4'd0), bcd[11:8] != 4'd0};
   endfunction

   function automatic logic [7:0] dig(input logic [3:0] d);
      return CH_ZERO + {4'b0, d};
   endfunction

   // Output decisions against the caches
   assign need_cur  = !curknown_ff || (currow_ff != job_data.row)
                      || (curcol_ff != {1'b0, job_data.column});
   assign need_back = !bknown_ff || (cback_ff != job_data.back);
   assign need_fore = (job_data.glyph != CH_SPACE)
                      && (!fknown_ff || (cfore_ff != job_data.fore));

   // Byte slot mask of a new job
   always_comb begin
      new_mask = '0;
      case (job_data.kind)
         JOB_START: new_mask[SLOT_START +: 8] = '1;
         JOB_END:   new_mask[SLOT_END +: 12] = '1;
         JOB_CELL: begin
            if (need_cur) begin
               new_mask[SLOT_CUR +: 2]     = '1;
               new_mask[SLOT_CUR + 2 +: 3] = dig_en(job_data.row_bcd);
               new_mask[SLOT_CUR + 5]      = 1'b1;
               new_mask[SLOT_CUR + 6 +: 3] = dig_en(job_data.col_bcd);
               new_mask[SLOT_CUR + 9]      = 1'b1;
            end
            if (need_back) begin
               new_mask[SLOT_BACK +: 7]       = '1;
               new_mask[SLOT_BACK + 7 +: 3]   = dig_en(job_data.br_bcd);
               new_mask[SLOT_BACK + 10]       = 1'b1;
               new_mask[SLOT_BACK + 11 +: 3]  = dig_en(job_data.bg_bcd);
               new_mask[SLOT_BACK + 14]       = 1'b1;
               new_mask[SLOT_BACK + 15 +: 3]  = dig_en(job_data.bb_bcd);
               new_mask[SLOT_BACK + 18]       = 1'b1;
            end
            if (need_fore) begin
               new_mask[SLOT_FORE +: 7]       = '1;
               new_mask[SLOT_FORE + 7 +: 3]   = dig_en(job_data.fr_bcd);
               new_mask[SLOT_FORE + 10]       = 1'b1;
               new_mask[SLOT_FORE + 11 +: 3]  = dig_en(job_data.fg_bcd);
               new_mask[SLOT_FORE + 14]       = 1'b1;
               new_mask[SLOT_FORE + 15 +: 3]  = dig_en(job_data.fb_bcd);
               new_mask[SLOT_FORE + 18]       = 1'b1;
            end
            new_mask[SLOT_GLYPH] = 1'b1;
            if (job_data.glyph == GLYPH_HALF) begin
               new_mask[SLOT_GLYPH + 1 +: 2] = '1;
            end
         end
         default: new_mask = '0;
      endcase
   end

   // First pending slot
   always_comb begin
      pc = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) pc = SLOT_W'(i);
      end
      rest = mask_ff & ~(NUM_SLOTS'(1) << pc);
   end

   // Byte of the current slot
   always_comb begin
      case (pc)
         SLOT_CUR, SLOT_BACK, SLOT_FORE, SLOT_START, SLOT_END, SLOT_END + 4:
            rsp_out_byte = CH_ESC;
         SLOT_CUR + 1, SLOT_BACK + 1, SLOT_FORE + 1, SLOT_START + 1, SLOT_END + 1,
         SLOT_END + 5:
            rsp_out_byte = CH_LBR;
         SLOT_CUR + 2:  rsp_out_byte = dig(job_ff.row_bcd[11:8]);
         SLOT_CUR + 3:  rsp_out_byte = dig(job_ff.row_bcd[7:4]);
         SLOT_CUR + 4:  rsp_out_byte = dig(job_ff.row_bcd[3:0]);
         SLOT_CUR + 6:  rsp_out_byte = dig(job_ff.col_bcd[11:8]);
         SLOT_CUR + 7:  rsp_out_byte = dig(job_ff.col_bcd[7:4]);
         SLOT_CUR + 8:  rsp_out_byte = dig(job_ff.col_bcd[3:0]);
         SLOT_CUR + 9:  rsp_out_byte = CH_BIG_H;
         SLOT_CUR + 5, SLOT_BACK + 4, SLOT_BACK + 6, SLOT_BACK + 10, SLOT_BACK + 14,
         SLOT_FORE + 4, SLOT_FORE + 6, SLOT_FORE + 10, SLOT_FORE + 14:
            rsp_out_byte = CH_SEMI;
         SLOT_BACK + 2: rsp_out_byte = CH_FOUR;
         SLOT_FORE + 2: rsp_out_byte = CH_THREE;
         SLOT_BACK + 3, SLOT_FORE + 3: rsp_out_byte = CH_EIGHT;
         SLOT_BACK + 5, SLOT_FORE + 5, SLOT_START + 3, SLOT_START + 5, SLOT_END + 7,
         SLOT_END + 9:
            rsp_out_byte = CH_TWO;
         SLOT_BACK + 7:  rsp_out_byte = dig(job_ff.br_bcd[11:8]);
         SLOT_BACK + 8:  rsp_out_byte = dig(job_ff.br_bcd[7:4]);
         SLOT_BACK + 9:  rsp_out_byte = dig(job_ff.br_bcd[3:0]);
         SLOT_BACK + 11: rsp_out_byte = dig(job_ff.bg_bcd[11:8]);
         SLOT_BACK + 12: rsp_out_byte = dig(job_ff.bg_bcd[7:4]);
         SLOT_BACK + 13: rsp_out_byte = dig(job_ff.bg_bcd[3:0]);
         SLOT_BACK + 15: rsp_out_byte = dig(job_ff.bb_bcd[11:8]);
         SLOT_BACK + 16: rsp_out_byte = dig(job_ff.bb_bcd[7:4]);
         SLOT_BACK + 17: rsp_out_byte = dig(job_ff.bb_bcd[3:0]);
         SLOT_FORE + 7:  rsp_out_byte = dig(job_ff.fr_bcd[11:8]);
         SLOT_FORE + 8:  rsp_out_byte = dig(job_ff.fr_bcd[7:4]);
         SLOT_FORE + 9:  rsp_out_byte = dig(job_ff.fr_bcd[3:0]);
         SLOT_FORE + 11: rsp_out_byte = dig(job_ff.fg_bcd[11:8]);
         SLOT_FORE + 12: rsp_out_byte = dig(job_ff.fg_bcd[7:4]);
         SLOT_FORE + 13: rsp_out_byte = dig(job_ff.fg_bcd[3:0]);
         SLOT_FORE + 15: rsp_out_byte = dig(job_ff.fb_bcd[11:8]);
         SLOT_FORE + 16: rsp_out_byte = dig(job_ff.fb_bcd[7:4]);
         SLOT_FORE + 17: rsp_out_byte = dig(job_ff.fb_bcd[3:0]);
         SLOT_BACK + 18, SLOT_FORE + 18, SLOT_END + 3: rsp_out_byte = CH_M;
         SLOT_GLYPH:
            rsp_out_byte = (job_ff.glyph == GLYPH_HALF) ? UTF_B0 : job_ff.glyph;
         SLOT_GLYPH + 1: rsp_out_byte = UTF_B1;
         SLOT_GLYPH + 2: rsp_out_byte = UTF_B2;
         SLOT_START + 2, SLOT_END + 6: rsp_out_byte = CH_QUEST;
         SLOT_START + 4, SLOT_END + 2, SLOT_END + 8: rsp_out_byte = CH_ZERO;
         SLOT_START + 6, SLOT_END + 10: rsp_out_byte = CH_SIX;
         SLOT_START + 7: rsp_out_byte = CH_H;
         SLOT_END + 11:  rsp_out_byte = CH_L;
         default:        rsp_out_byte = CH_ZERO;
      endcase
   end

   // Handshake and next job
   assign rsp_valid     = active_ff;
   assign rsp_last_byte = (rest == '0);
   assign load          = job_valid && (!active_ff || (rsp_ready && rsp_last_byte));
   assign job_ready     = load;

   always_comb begin
      active_in = active_ff;
      mask_in   = mask_ff;
      if (load) begin
         active_in = 1'b1;
         mask_in   = new_mask;
      end else if (active_ff && rsp_ready) begin
         active_in = !rsp_last_byte;
         mask_in   = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         mask_ff     <= '0;
         bknown_ff   <= 1'b0;
         fknown_ff   <= 1'b0;
         curknown_ff <= 1'b0;
         cback_ff    <= '0;
         cfore_ff    <= '0;
         currow_ff   <= '0;
         curcol_ff   <= '0;
      end else begin
         active_ff <= active_in;
         mask_ff   <= mask_in;
         if (load) begin
            if (job_data.kind == JOB_CELL) begin
               if (need_back) begin
                  cback_ff  <= job_data.back;
                  bknown_ff <= 1'b1;
               end
               if (need_fore) begin
                  cfore_ff  <= job_data.fore;
                  fknown_ff <= 1'b1;
               end
               currow_ff   <= job_data.row;
               curcol_ff   <= {1'b0, job_data.column} + 8'd1;
               curknown_ff <= 1'b1;
            end else begin
               bknown_ff   <= 1'b0;
               fknown_ff   <= 1'b0;
               curknown_ff <= 1'b0;
            end
         end
      end
      if (load) begin
         job_ff <= job_data;
      end
   end

   a_active_has_bytes: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (mask_ff != '0)) else $error("active job with no bytes left");
   a_frame_forgets: assert property (@(posedge clock) disable iff (reset)
      (load && job_data.kind != JOB_CELL) |=> !curknown_ff && !bknown_ff && !fknown_ff)
      else $error("frame marker kept caches");
   a_cell_sets_cursor: assert property (@(posedge clock) disable iff (reset)
      (load && job_data.kind == JOB_CELL) |=> curknown_ff && bknown_ff)
      else $error("cell left cursor or background unknown");
endmodule

FILE: rtl/terminal_cell_delta_encoder_core.sv
// Top level of the terminal cell delta encoder: register, front end, queue, back end.
//
// Requests are frame start, frame end or cell. The front end takes one request per
// cycle unless held by a full queue, reads the shown-cell store (registered read),
// compares in the next cycle and queues a job only when there is text to send; an
// unchanged or out-of-range cell produces nothing. The back end sends one byte per
// cycle when rsp_ready is high; a job has 8 bytes for frame start, 12 for frame end
// and 1 to 51 for a changed cell (cursor move, background code, foreground code,
// glyph). A four-entry queue lets the front keep comparing while the back streams
// text. After reset the store is cleared one entry per cycle, MAX_ROWS*MAX_COLUMNS
// entries (8192 by default), with req_ready low; csr writes are taken at any time.
module terminal_cell_delta_encoder_core #(
   parameter int MAX_COLUMNS = tcde_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tcde_pkg::DEF_MAX_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_line_width,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [5:0] req_row,
   input  logic [6:0] req_column,
   input  logic [7:0] req_back_red,
   input  logic [7:0] req_back_green,
   input  logic [7:0] req_back_blue,
   input  logic [7:0] req_fore_red,
   input  logic [7:0] req_fore_green,
   input  logic [7:0] req_fore_blue,
   input  logic [7:0] req_glyph,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte
);
   import tcde_pkg::*;

   logic [7:0] line_width_ff, line_width_in;
   logic       fq_valid, fq_ready, qb_valid, qb_ready;
   job_type    fq_data, qb_data;
   logic       clearing;

   // Line width register
   assign csr_ready     = 1'b1;
   assign line_width_in = (csr_valid && csr_ready) ? csr_line_width : line_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   tcde_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_row    (req_row),
      .req_column (req_column),
      .req_back   ({req_back_red, req_back_green, req_back_blue}),
      .req_fore   ({req_fore_red, req_fore_green, req_fore_blue}),
      .req_glyph  (req_glyph),
      .job_valid  (fq_valid),
      .job_ready  (fq_ready),
      .job_data   (fq_data),
      .clearing   (clearing)
   );

   tcde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   tcde_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (qb_valid),
      .job_ready     (qb_ready),
      .job_data      (qb_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   a_no_output_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid) else $error("output during store clear");
   a_no_job_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !qb_valid) else $error("queued job during store clear");
   a_width_holds: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(line_width_ff)) else $error("line width changed unwritten");
endmodule
